>>> rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// shared types, character codes and helpers of the infix to postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CARET = 8'h5E;

   localparam logic [2:0] PREC_POW  = 3'd5;
   localparam logic [2:0] PREC_MUL  = 3'd4;
   localparam logic [2:0] PREC_ADD  = 3'd3;
   localparam logic [2:0] PREC_NONE = 3'd0;

   localparam logic [1:0] ERR_NONE      = 2'b00;
   localparam logic [1:0] ERR_OVERFLOW  = 2'b01;
   localparam logic [1:0] ERR_UNMATCHED = 2'b10;

   typedef enum logic [1:0] {
      TOK_OPERAND,
      TOK_OPEN,
      TOK_CLOSE,
      TOK_OPERATOR
   } tok_class_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_TOKEN,
      EMIT_STACK,
      EMIT_MARKER
   } emit_sel_type;

   typedef struct packed {
      logic         accept;
      emit_sel_type emit_sel;
      logic         emit_last;
      logic         emit_unmatched;
      logic         pop;
      logic         push;
      logic         set_unmatched;
      logic         clear_err;
   } itp_cmd_type;

   typedef struct packed {
      tok_class_type tok_class;
      logic          expr_end;
      logic          count_zero;
      logic          count_one;
      logic          count_two;
      logic          bottom_open;
      logic          top_is_open;
      logic          top_prec_ge;
      logic          out_free;
      logic          emitted;
   } itp_status_type;

   function automatic logic [2:0] prec_of(input logic [7:0] c);
      logic [2:0] p;
      unique case (c)
         CH_CARET:          p = PREC_POW;
         CH_STAR, CH_SLASH: p = PREC_MUL;
         CH_PLUS, CH_MINUS: p = PREC_ADD;
         default:           p = PREC_NONE;
      endcase
      return p;
   endfunction

   function automatic tok_class_type classify(input logic [7:0] c);
      tok_class_type t;
      unique case (c)
         CH_OPEN:  t = TOK_OPEN;
         CH_CLOSE: t = TOK_CLOSE;
         CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS: t = TOK_OPERATOR;
         default:  t = TOK_OPERAND;
      endcase
      return t;
   endfunction

endpackage

>>> rtl/core/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/itp_dp.sv
// ----------------------------------------------------------------------------
// itp_dp
// datapath: token register, operator stack, error flags and result register
// ----------------------------------------------------------------------------
module itp_dp #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_token_char,
   input  logic                   req_expr_end,
   input  itp_pkg::itp_cmd_type   cmd,
   output itp_pkg::itp_status_type status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_char_valid,
   output logic                   rsp_out_last,
   output logic [1:0]             rsp_error_code
);
   import itp_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [7:0]       tok_ff, tok_in;
   logic             end_ff, end_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       err_ff, err_in;
   logic             emitted_ff, emitted_in;
   logic             bottom_open_ff, bottom_open_in;
   logic             valid_ff, valid_in;
   logic [7:0]       char_ff, char_in;
   logic             cvalid_ff, cvalid_in;
   logic             last_ff, last_in;
   logic [1:0]       code_ff, code_in;

   logic             full;
   logic             do_write;
   logic [CNT_W-1:0] count_dec;
   logic [7:0]       top_char;
   logic             do_emit;

   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign do_write  = cmd.push && !full;
   assign count_dec = count_ff - CNT_W'(1);
   assign do_emit   = (cmd.emit_sel != EMIT_NONE);

   itp_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (tok_ff),
      .rd_addr (count_dec[ADDR_W-1:0]),
      .rd_data (top_char)
   );

   always_comb begin
      tok_in     = cmd.accept ? req_token_char : tok_ff;
      end_in     = cmd.accept ? req_expr_end : end_ff;
      emitted_in = cmd.accept ? 1'b0 : (emitted_ff | do_emit);

      // bottom entry only changes on a push into an empty stack
      bottom_open_in = bottom_open_ff;
      if (do_write && count_ff == '0) begin
         bottom_open_in = (tok_ff == CH_OPEN);
      end

      count_in = count_ff;
      if (cmd.pop) begin
         count_in = count_dec;
      end else if (do_write) begin
         count_in = count_ff + CNT_W'(1);
      end

      err_in = err_ff;
      if (cmd.clear_err) begin
         err_in = ERR_NONE;
      end else begin
         if (cmd.push && full) begin
            err_in = err_in | ERR_OVERFLOW;
         end
         if (cmd.set_unmatched) begin
            err_in = err_in | ERR_UNMATCHED;
         end
      end

      // result register frees itself when the word is taken
      valid_in  = valid_ff && rsp_stall;
      char_in   = char_ff;
      cvalid_in = cvalid_ff;
      last_in   = last_ff;
      code_in   = code_ff;
      if (do_emit) begin
         valid_in  = 1'b1;
         last_in   = cmd.emit_last;
         code_in   = cmd.emit_last ?
                     (err_ff | (cmd.emit_unmatched ? ERR_UNMATCHED : ERR_NONE)) : ERR_NONE;
         unique case (cmd.emit_sel)
            EMIT_TOKEN: begin
               char_in   = tok_ff;
               cvalid_in = 1'b1;
            end
            EMIT_STACK: begin
               char_in   = top_char;
               cvalid_in = 1'b1;
            end
            EMIT_MARKER: begin
               char_in   = 8'h00;
               cvalid_in = 1'b0;
            end
            default: begin
               char_in   = char_ff;
               cvalid_in = cvalid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         err_ff         <= ERR_NONE;
         emitted_ff     <= 1'b0;
         bottom_open_ff <= 1'b0;
         valid_ff       <= 1'b0;
      end else begin
         count_ff       <= count_in;
         err_ff         <= err_in;
         emitted_ff     <= emitted_in;
         bottom_open_ff <= bottom_open_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff    <= tok_in;
      end_ff    <= end_in;
      char_ff   <= char_in;
      cvalid_ff <= cvalid_in;
      last_ff   <= last_in;
      code_ff   <= code_in;
   end

   always_comb begin
      status.tok_class   = classify(tok_ff);
      status.expr_end    = end_ff;
      status.count_zero  = (count_ff == '0);
      status.count_one   = (count_ff == CNT_W'(1));
      status.count_two   = (count_ff == CNT_W'(2));
      status.bottom_open = bottom_open_ff;
      status.top_is_open = (top_char == CH_OPEN);
      status.top_prec_ge = (prec_of(top_char) >= prec_of(tok_ff));
      status.out_free    = !valid_ff || !rsp_stall;
      status.emitted     = emitted_ff;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_char_valid = cvalid_ff;
   assign rsp_out_last   = last_ff;
   assign rsp_error_code = code_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop from empty stack");

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !cvalid_ff |-> last_ff)
      else $error("end marker without last flag");

   a_code_on_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && code_ff != ERR_NONE |-> last_ff)
      else $error("error code on a non-final word");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      do_emit |-> !valid_ff || !rsp_stall)
      else $error("result register overwritten while stalled");

endmodule

>>> rtl/core/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl
// controller: sequences accept, stack scan, push and end-of-expression flush
// ----------------------------------------------------------------------------
module itp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  itp_pkg::itp_status_type status,
   output itp_pkg::itp_cmd_type    cmd
);
   import itp_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE        = 8'b0000_0001,
      ST_TOKEN       = 8'b0000_0010,
      ST_FETCH       = 8'b0000_0100,
      ST_DECIDE      = 8'b0000_1000,
      ST_PUSH        = 8'b0001_0000,
      ST_END         = 8'b0010_0000,
      ST_FLUSH_FETCH = 8'b0100_0000,
      ST_FLUSH_POP   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      is_close;

   assign is_close  = (status.tok_class == TOK_CLOSE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_TOKEN;
            end
         end
         ST_TOKEN: begin
            // token register is loaded now, branch on its class
            unique case (status.tok_class)
               TOK_OPEN: state_in = ST_PUSH;
               TOK_CLOSE, TOK_OPERATOR: state_in = ST_FETCH;
               default: begin
                  if (status.out_free) begin
                     cmd.emit_sel  = EMIT_TOKEN;
                     cmd.emit_last = status.expr_end && status.count_zero;
                     state_in      = ST_END;
                  end
               end
            endcase
         end
         ST_FETCH: begin
            if (status.count_zero) begin
               if (is_close) begin
                  cmd.set_unmatched = 1'b1;
                  state_in          = ST_END;
               end else begin
                  state_in = ST_PUSH;
               end
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (is_close) begin
               if (status.top_is_open) begin
                  cmd.pop  = 1'b1;
                  state_in = ST_END;
               end else if (status.out_free) begin
                  // emptying the stack here means the close had no match;
                  // a matching '(' at the bottom also leaves nothing to flush
                  cmd.emit_sel       = EMIT_STACK;
                  cmd.emit_last      = status.expr_end &&
                                       (status.count_one ||
                                        (status.count_two && status.bottom_open));
                  cmd.emit_unmatched = status.count_one;
                  cmd.pop            = 1'b1;
                  state_in           = ST_FETCH;
               end
            end else if (status.top_prec_ge) begin
               if (status.out_free) begin
                  cmd.emit_sel = EMIT_STACK;
                  cmd.pop      = 1'b1;
                  state_in     = ST_FETCH;
               end
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_END;
         end
         ST_END: begin
            state_in = status.expr_end ? ST_FLUSH_FETCH : ST_IDLE;
         end
         ST_FLUSH_FETCH: begin
            if (!status.count_zero) begin
               state_in = ST_FLUSH_POP;
            end else if (status.emitted) begin
               cmd.clear_err = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_sel  = EMIT_MARKER;
               cmd.emit_last = 1'b1;
               cmd.clear_err = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FLUSH_POP: begin
            if (status.out_free) begin
               cmd.emit_sel  = EMIT_STACK;
               cmd.emit_last = status.count_one;
               cmd.pop       = 1'b1;
               state_in      = ST_FLUSH_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("second word taken while one is in work");

   a_pop_push_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && cmd.push))
      else $error("pop and push in one cycle");

endmodule

>>> rtl/core/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting-yard conversion of an infix character stream to postfix order
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one expression character per word, req_expr_end on the
//   final character. a word is taken when req_valid is high and req_stall
//   low; req_stall stays high while a character is being worked on.
//   rsp_ channel: postfix characters in order; rsp_out_last marks the final
//   word and rsp_error_code is only non-zero there. a final character that
//   yields nothing gives one bare end marker with rsp_char_valid low.
// sequence
//   an operand is emitted from the token state. '(' is pushed. an operator
//   pops and emits each entry of equal or higher precedence, then is pushed
//   once the stack is empty or its top is weaker or a '('. ')' pops and emits
//   entries until it pops its '(' or the stack runs empty. after the final
//   character every entry left on the stack is emitted. each emit waits while stalled.
// reset and stall
//   reset empties the stack and clears the error flags and the output valid flag.
//   while rsp_stall is high a valid output word holds and the controller waits
//   at its next emit.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_token_char,
   input  logic       req_expr_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_out_last,
   output logic [1:0] rsp_error_code
);
   import itp_pkg::*;

   itp_cmd_type    cmd;
   itp_status_type status;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itp_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_token_char (req_token_char),
      .req_expr_end   (req_expr_end),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_out_last   (rsp_out_last),
      .rsp_error_code (rsp_error_code)
   );

endmodule
